// ----- src/cats_pkg.sv -----
// cats_pkg: shared types, constants and the crc-32/mpeg-2 byte update for the
// conditional-access table section parser; no dependencies
package cats_pkg;

    localparam int MAX_DESCRIPTORS   = 16;
    localparam int MIN_SECTION_BYTES = 12;
    localparam int MAX_SECTION_BYTES = 1024;

    localparam int LOOP_START    = 8;
    localparam int LOOP_OVERHEAD = 9;
    localparam int DESC_HDR      = 2;

    localparam logic [31:0] CRC_POLY = 32'h04C11DB7;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    localparam int ADDR_W   = (MAX_DESCRIPTORS > 1) ? $clog2(MAX_DESCRIPTORS) : 1;
    localparam int CNT_W    = $clog2(MAX_DESCRIPTORS + 1);
    localparam int IDX_W    = $clog2(MAX_SECTION_BYTES + 2);
    localparam int NEXT_W   = $clog2(MAX_SECTION_BYTES + 257);
    localparam int LOOP_W   = 14;
    localparam int OFFSET_W = 12;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_CRC_ERR  = 2'd1;
    localparam logic [1:0] STATUS_SIZE_ERR = 2'd2;

    localparam logic KIND_DESCRIPTOR = 1'b0;
    localparam logic KIND_SUMMARY    = 1'b1;

    typedef struct packed {
        logic [7:0] section_byte;
        logic       last_byte;
    } cats_in_t;

    typedef struct packed {
        logic                result_kind;
        logic                last_result;
        logic [7:0]          desc_tag;
        logic [7:0]          desc_len;
        logic [OFFSET_W-1:0] descriptor_offset;
        logic [7:0]          tbl_id;
        logic [11:0]         sect_len;
        logic [4:0]          ver_num;
        logic                current_next;
        logic [7:0]          sect_num;
        logic [7:0]          last_sect_num;
        logic [1:0]          status;
    } cats_out_t;

    typedef struct packed {
        logic [7:0]          tag;
        logic [7:0]          len;
        logic [OFFSET_W-1:0] offset;
    } desc_rec_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        desc_rec_t         data;
    } ram_wr_t;

    typedef struct packed {
        logic update;
        logic clear;
    } crc_ctrl_t;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_EMIT,
        ST_WAIT,
        ST_SUM
    } emit_state_t;

    // msb-first update of the crc register by one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {b, 24'h000000};
        for (int i = 0; i < 8; i++) begin
            c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

// ----- src/cats_crc32.sv -----
// cats_crc32: running crc-32/mpeg-2 register over the section bytes
// depends on cats_pkg
module cats_crc32
    import cats_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  crc_ctrl_t  ctrl,
    input  logic [7:0] data_byte,
    output logic       residue_zero
);

    logic [31:0] crc_reg;
    logic [31:0] crc_upd;

    assign crc_upd      = crc_byte(crc_reg, data_byte);
    // residue including the byte of this transaction
    assign residue_zero = (crc_upd == 32'h0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= CRC_INIT;
        end else if (ctrl.clear) begin
            crc_reg <= CRC_INIT;
        end else if (ctrl.update) begin
            crc_reg <= crc_upd;
        end
    end

endmodule

// ----- src/cats_desc_ram.sv -----
// cats_desc_ram: descriptor record store, one write and one registered read port
// depends on cats_pkg
module cats_desc_ram
    import cats_pkg::*;
(
    input  logic              aclk,
    input  ram_wr_t           wr,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output desc_rec_t         rd_data
);

    desc_rec_t mem [MAX_DESCRIPTORS];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- src/ca_table_section_parser.sv -----
// ca_table_section_parser: top level, header capture, descriptor walk and result sequencer
// depends on cats_pkg, cats_crc32, cats_desc_ram
//
// Takes one section byte per cycle while receiving. Once the byte marked last_byte is taken,
// input stalls while results go out: each stored descriptor record is read through the
// descriptor memory's registered read port and then loaded into the output register, and
// the summary goes last, so the next byte is accepted only after the summary has been loaded,
// which waits on any result-side stall. Descriptor records live in a small memory that needs
// no clearing after reset; a size error gives the summary alone.
module ca_table_section_parser
    import cats_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  cats_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output cats_out_t m_data
);

    emit_state_t state_reg, state_next;

    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic [NEXT_W-1:0]        next_at_reg, next_at_next;
    logic signed [LOOP_W-1:0] loop_rem_reg, loop_rem_next;
    logic [7:0]               pend_tag_reg, pend_tag_next;
    logic                     pend_reg, pend_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [7:0]               hdr_tid_reg, hdr_tid_next;
    logic [11:0]              hdr_len_reg, hdr_len_next;
    logic [4:0]               hdr_ver_reg, hdr_ver_next;
    logic                     hdr_cur_reg, hdr_cur_next;
    logic [7:0]               hdr_sec_reg, hdr_sec_next;
    logic [7:0]               hdr_last_reg, hdr_last_next;

    logic [CNT_W-1:0] emit_cnt_reg, emit_cnt_next;
    logic [CNT_W-1:0] emit_ptr_reg, emit_ptr_next;
    cats_out_t        sum_reg, sum_next;
    logic             m_valid_reg, m_valid_next;
    cats_out_t        m_data_reg, m_data_next;

    logic        accept;
    logic        out_free;
    logic        in_loop;
    logic        advance;
    logic        take_tag;
    logic        size_err;
    logic        crc_ok;
    logic        rd_en;
    logic [7:0]  b;
    logic [8:0]  step;
    ram_wr_t     ram_wr;
    desc_rec_t   rd_data;
    crc_ctrl_t   crc_ctrl;
    logic [NEXT_W-1:0] idx_ext;

    assign s_ready  = (state_reg == ST_RUN);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign b        = s_data.section_byte;
    assign step     = {1'b0, b} + 9'(DESC_HDR);
    assign idx_ext  = NEXT_W'(idx_reg);

    assign in_loop  = (idx_reg >= IDX_W'(LOOP_START)) && (idx_reg < IDX_W'(MAX_SECTION_BYTES));
    assign advance  = in_loop && pend_reg && (idx_ext == next_at_reg + NEXT_W'(1));
    assign take_tag = in_loop && !pend_reg && (idx_ext == next_at_reg)
                      && (loop_rem_reg >= LOOP_W'(DESC_HDR))
                      && (cnt_reg < CNT_W'(MAX_DESCRIPTORS));

    assign crc_ctrl.update = accept;
    assign crc_ctrl.clear  = accept && s_data.last_byte;

    cats_crc32 u_crc (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (crc_ctrl),
        .data_byte    (b),
        .residue_zero (crc_ok)
    );

    cats_desc_ram u_ram (
        .aclk    (aclk),
        .wr      (ram_wr),
        .rd_en   (rd_en),
        .rd_addr (emit_ptr_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    // byte walk: header capture and descriptor loop
    always_comb begin
        idx_next      = idx_reg;
        next_at_next  = next_at_reg;
        loop_rem_next = loop_rem_reg;
        pend_tag_next = pend_tag_reg;
        pend_next     = pend_reg;
        cnt_next      = cnt_reg;
        hdr_tid_next  = hdr_tid_reg;
        hdr_len_next  = hdr_len_reg;
        hdr_ver_next  = hdr_ver_reg;
        hdr_cur_next  = hdr_cur_reg;
        hdr_sec_next  = hdr_sec_reg;
        hdr_last_next = hdr_last_reg;
        ram_wr.en     = 1'b0;
        ram_wr.addr   = cnt_reg[ADDR_W-1:0];
        ram_wr.data   = '{tag: pend_tag_reg, len: b, offset: OFFSET_W'(next_at_reg)};

        if (accept) begin
            case (idx_reg)
                IDX_W'(0): hdr_tid_next = b;
                IDX_W'(1): hdr_len_next = {b[3:0], 8'h00};
                IDX_W'(2): begin
                    hdr_len_next  = {hdr_len_reg[11:8], b};
                    loop_rem_next = LOOP_W'({hdr_len_reg[11:8], b}) - LOOP_W'(LOOP_OVERHEAD);
                end
                IDX_W'(5): begin
                    hdr_ver_next = b[5:1];
                    hdr_cur_next = b[0];
                end
                IDX_W'(6): hdr_sec_next  = b;
                IDX_W'(7): hdr_last_next = b;
                default: ;
            endcase

            if (advance) begin
                if (cnt_reg < CNT_W'(MAX_DESCRIPTORS)) begin
                    ram_wr.en = 1'b1;
                    cnt_next  = cnt_reg + CNT_W'(1);
                end
                next_at_next  = next_at_reg + NEXT_W'(step);
                loop_rem_next = loop_rem_reg - LOOP_W'(step);
                pend_next     = 1'b0;
            end else if (take_tag) begin
                pend_tag_next = b;
                pend_next     = 1'b1;
            end

            // saturating byte count
            if (idx_reg <= IDX_W'(MAX_SECTION_BYTES)) begin
                idx_next = idx_reg + IDX_W'(1);
            end
        end
    end

    assign size_err = (idx_next < IDX_W'(MIN_SECTION_BYTES))
                      || (idx_next > IDX_W'(MAX_SECTION_BYTES));

    // result sequencer
    always_comb begin
        state_next    = state_reg;
        emit_cnt_next = emit_cnt_reg;
        emit_ptr_next = emit_ptr_reg;
        sum_next      = sum_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        rd_en         = 1'b0;

        case (state_reg)
            ST_RUN: begin
                if (accept && s_data.last_byte) begin
                    sum_next             = '0;
                    sum_next.result_kind = KIND_SUMMARY;
                    sum_next.last_result = 1'b1;
                    emit_ptr_next        = '0;
                    if (size_err) begin
                        sum_next.status = STATUS_SIZE_ERR;
                        emit_cnt_next   = '0;
                        state_next      = ST_SUM;
                    end else begin
                        sum_next.tbl_id        = hdr_tid_reg;
                        sum_next.sect_len      = hdr_len_reg;
                        sum_next.ver_num       = hdr_ver_reg;
                        sum_next.current_next  = hdr_cur_reg;
                        sum_next.sect_num      = hdr_sec_reg;
                        sum_next.last_sect_num = hdr_last_reg;
                        sum_next.status = crc_ok ? STATUS_OK : STATUS_CRC_ERR;
                        emit_cnt_next   = cnt_next;
                        state_next      = (cnt_next == '0) ? ST_SUM : ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                rd_en      = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                // read data holds until the output register frees up
                if (out_free) begin
                    m_valid_next                  = 1'b1;
                    m_data_next                   = '0;
                    m_data_next.result_kind       = KIND_DESCRIPTOR;
                    m_data_next.desc_tag          = rd_data.tag;
                    m_data_next.desc_len          = rd_data.len;
                    m_data_next.descriptor_offset = rd_data.offset;
                    emit_ptr_next                 = emit_ptr_reg + CNT_W'(1);
                    state_next = (emit_ptr_reg + CNT_W'(1) == emit_cnt_reg) ? ST_SUM : ST_EMIT;
                end
            end
            ST_SUM: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = sum_reg;
                    state_next   = ST_RUN;
                end
            end
            default: state_next = ST_RUN;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RUN;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && s_data.last_byte)) begin
            idx_reg      <= '0;
            next_at_reg  <= NEXT_W'(LOOP_START);
            loop_rem_reg <= '0;
            pend_tag_reg <= '0;
            pend_reg     <= 1'b0;
            cnt_reg      <= '0;
            hdr_tid_reg  <= '0;
            hdr_len_reg  <= '0;
            hdr_ver_reg  <= '0;
            hdr_cur_reg  <= 1'b0;
            hdr_sec_reg  <= '0;
            hdr_last_reg <= '0;
        end else begin
            idx_reg      <= idx_next;
            next_at_reg  <= next_at_next;
            loop_rem_reg <= loop_rem_next;
            pend_tag_reg <= pend_tag_next;
            pend_reg     <= pend_next;
            cnt_reg      <= cnt_next;
            hdr_tid_reg  <= hdr_tid_next;
            hdr_len_reg  <= hdr_len_next;
            hdr_ver_reg  <= hdr_ver_next;
            hdr_cur_reg  <= hdr_cur_next;
            hdr_sec_reg  <= hdr_sec_next;
            hdr_last_reg <= hdr_last_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            emit_cnt_reg <= '0;
            emit_ptr_reg <= '0;
        end else begin
            m_valid_reg  <= m_valid_next;
            emit_cnt_reg <= emit_cnt_next;
            emit_ptr_reg <= emit_ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg    <= sum_next;
        m_data_reg <= m_data_next;
    end

    // a marked byte always starts a result run
    a_last_starts_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.last_byte) |=> (state_reg != ST_RUN))
        else $error("last byte did not start a result run");

    // the store never overfills
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg <= CNT_W'(MAX_DESCRIPTORS)) && (emit_cnt_reg <= CNT_W'(MAX_DESCRIPTORS)))
        else $error("descriptor count beyond store depth");

    // reads stay inside the records stored for this section
    a_read_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT || state_reg == ST_WAIT) |-> (emit_ptr_reg < emit_cnt_reg))
        else $error("descriptor read past stored records");

    // a descriptor record is only on show while the run is still going
    a_desc_before_summary: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_data_reg.result_kind == KIND_DESCRIPTOR)) |-> (state_reg != ST_RUN))
        else $error("descriptor record outside a result run");

    a_index_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= IDX_W'(MAX_SECTION_BYTES + 1))
        else $error("byte index beyond saturation point");

endmodule
